### hdl/ijd_pkg.sv
// Shared types and constants for the interval jitter detector.
// No dependencies; imported by every module of the block.
package ijd_pkg;

	localparam int WINDOW_DEPTH_DEF  = 6;
	localparam int INTERVAL_BITS_DEF = 24;

	localparam int THR_W       = 24;
	localparam int FACTOR_W    = 8;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 1;

	localparam logic [THR_W-1:0]    THR_RESET    = 24'd10;
	localparam logic [FACTOR_W-1:0] FACTOR_RESET = 8'd20;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_STDEV_THRESHOLD = 1'b0,
		REG_OUTLIER_FACTOR  = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DROP_SQ,
		ST_DROP,
		ST_OUT_MUL,
		ST_DECIDE,
		ST_PUSH_SQ,
		ST_PUSH,
		ST_SUM_SQ,
		ST_NT_SQ,
		ST_CMP
	} state_t;

	// one strobe per datapath step
	typedef struct packed {
		logic load;
		logic sq_old;
		logic drop;
		logic out_mul;
		logic decide;
		logic sq_new;
		logic push;
		logic sq_sum;
		logic sq_nt;
		logic result;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic push_ok;
	} stat_t;

endpackage

### hdl/ijd_ctrl.sv
// Sequencer for the interval jitter detector: input/output transfer control
// and datapath step strobes. Depends on ijd_pkg.
module ijd_ctrl
	import ijd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_stall,
	output logic  out_valid,
	input  logic  out_stall,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.result) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.full ? ST_DROP_SQ : ST_OUT_MUL;
				end
			end
			ST_DROP_SQ: begin
				cmd.sq_old = 1'b1;
				state_d    = ST_DROP;
			end
			ST_DROP: begin
				cmd.drop = 1'b1;
				state_d  = ST_OUT_MUL;
			end
			ST_OUT_MUL: begin
				cmd.out_mul = 1'b1;
				state_d     = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = stat.push_ok ? ST_PUSH_SQ : ST_SUM_SQ;
			end
			ST_PUSH_SQ: begin
				cmd.sq_new = 1'b1;
				state_d    = ST_PUSH;
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_SUM_SQ;
			end
			ST_SUM_SQ: begin
				cmd.sq_sum = 1'b1;
				state_d    = ST_NT_SQ;
			end
			ST_NT_SQ: begin
				cmd.sq_nt = 1'b1;
				state_d   = ST_CMP;
			end
			ST_CMP: begin
				// wait for a free result slot
				if (!out_valid_q || !out_stall) begin
					cmd.result = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### hdl/ijd_dp.sv
// Datapath for the interval jitter detector: window, running sums, shared
// multiplier, config registers and result register. Depends on ijd_pkg.
module ijd_dp
	import ijd_pkg::*;
#(
	parameter int WINDOW_DEPTH  = WINDOW_DEPTH_DEF,
	parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [CFG_INDEX_W-1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0]             cfg_data,
	input  logic [31:0]                       now_ticks,
	input  cmd_t                              cmd,
	output stat_t                             stat,
	output logic                              flag,
	output logic [$clog2(WINDOW_DEPTH+1)-1:0] interval_count
);

	localparam int CW     = $clog2(WINDOW_DEPTH + 1);
	localparam int IDX_W  = $clog2(WINDOW_DEPTH);
	localparam int IB     = INTERVAL_BITS;
	localparam int SUM_W  = IB + $clog2(WINDOW_DEPTH);
	localparam int SQ_W   = 2 * IB + $clog2(WINDOW_DEPTH);
	localparam int NT_W   = THR_W + CW;
	localparam int MUL_W  = (SUM_W > NT_W) ? SUM_W : NT_W;
	localparam int PROD_W = 2 * MUL_W;
	localparam logic [32:0] INT_MAX = (33'd1 << IB) - 33'd1;

	// state with defined reset
	logic [31:0]         last_q;
	logic [CW-1:0]       fill_q;
	logic                used_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SQ_W-1:0]     sumsq_q;
	logic [THR_W-1:0]    thr_q;
	logic [FACTOR_W-1:0] factor_q;

	// payload
	logic [IB-1:0]     win [WINDOW_DEPTH];
	logic [IB-1:0]     newest_q;
	logic [IB-1:0]     diff_q;
	logic              lt_nz_q;
	logic [PROD_W-1:0] prod_q;
	logic [PROD_W-1:0] lhs_q;
	logic [NT_W-1:0]   nt_q;
	logic              flag_q;
	logic [CW-1:0]     count_q;

	logic [31:0]        diff32;
	logic [IB-1:0]      diff_sat;
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [PROD_W-1:0]  prod_w;
	logic [SQ_W+CW-1:0] lhs_w;
	logic [NT_W-1:0]    nt_w;
	logic               mul_en;
	logic               push_ok;

	assign diff32   = now_ticks - last_q;
	assign diff_sat = ({1'b0, diff32} > INT_MAX) ? INT_MAX[IB-1:0] : diff32[IB-1:0];

	// one outlier skip allowed; empty window never skips
	assign push_ok = lt_nz_q &&
		!(!used_q && (fill_q != '0) && (PROD_W'(diff_q) > prod_q));

	assign stat.full    = (fill_q == CW'(WINDOW_DEPTH));
	assign stat.push_ok = push_ok;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (cmd.sq_old) begin
			mul_a = MUL_W'(win[0]);
			mul_b = MUL_W'(win[0]);
		end else if (cmd.out_mul) begin
			mul_a = MUL_W'(newest_q);
			mul_b = MUL_W'(factor_q);
		end else if (cmd.sq_new) begin
			mul_a = MUL_W'(diff_q);
			mul_b = MUL_W'(diff_q);
		end else if (cmd.sq_sum) begin
			mul_a = MUL_W'(sum_q);
			mul_b = MUL_W'(sum_q);
		end else if (cmd.sq_nt) begin
			mul_a = MUL_W'(nt_q);
			mul_b = MUL_W'(nt_q);
		end
	end

	assign mul_en = cmd.sq_old | cmd.out_mul | cmd.sq_new | cmd.sq_sum | cmd.sq_nt;
	assign prod_w = mul_a * mul_b;
	assign lhs_w  = sumsq_q * fill_q;
	assign nt_w   = thr_q * fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= '0;
			fill_q   <= '0;
			used_q   <= 1'b0;
			sum_q    <= '0;
			sumsq_q  <= '0;
			thr_q    <= THR_RESET;
			factor_q <= FACTOR_RESET;
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_STDEV_THRESHOLD: thr_q    <= cfg_data[THR_W-1:0];
					REG_OUTLIER_FACTOR:  factor_q <= cfg_data[FACTOR_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				last_q <= now_ticks;
			end
			if (cmd.drop) begin
				fill_q  <= fill_q - CW'(1);
				sum_q   <= sum_q - SUM_W'(win[0]);
				sumsq_q <= sumsq_q - prod_q[SQ_W-1:0];
			end
			if (cmd.decide) begin
				if (push_ok) begin
					fill_q <= fill_q + CW'(1);
					sum_q  <= sum_q + SUM_W'(diff_q);
				end else if (lt_nz_q) begin
					used_q <= 1'b1;
				end
			end
			if (cmd.push) begin
				sumsq_q <= sumsq_q + prod_q[SQ_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			diff_q  <= diff_sat;
			lt_nz_q <= (last_q != '0);
		end
		if (cmd.drop) begin
			for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
				win[i] <= win[i+1];
			end
		end
		if (cmd.decide && push_ok) begin
			win[fill_q[IDX_W-1:0]] <= diff_q;
			newest_q               <= diff_q;
		end
		if (mul_en) begin
			prod_q <= prod_w;
		end
		if (cmd.sq_sum) begin
			lhs_q <= PROD_W'(lhs_w);
			nt_q  <= nt_w;
		end
		if (cmd.sq_nt) begin
			// n*sumsq - sum^2, never negative
			lhs_q <= lhs_q - prod_q;
		end
		if (cmd.result) begin
			flag_q  <= (fill_q < CW'(2)) | (lhs_q > prod_q);
			count_q <= fill_q;
		end
	end

	assign flag           = flag_q;
	assign interval_count = count_q;

endmodule

### hdl/interval_jitter_detector_core.sv
// Top level of the interval jitter detector: sequencer plus datapath.
// Depends on ijd_pkg, ijd_ctrl and ijd_dp.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+-----------------------------
//  in      | in  | in_valid  / in_stall    | now_ticks
//  out     | out | out_valid / out_stall   | flag, interval_count
//  cfg     | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// After a transfer on in, the sequencer runs OUT_MUL, DECIDE, PUSH_SQ, PUSH,
// SUM_SQ, NT_SQ and CMP, and the result is loaded into the output register
// at the end of CMP. When the window is full, DROP_SQ and DROP first drop
// the oldest interval; when no interval is stored, PUSH_SQ and PUSH are
// skipped. The single shared multiplier serves the squaring and scaling
// steps. in_stall stays high until the result is loaded and is low again
// the cycle after, so a waiting result does not block the next input; the
// next result then waits in the last step until out_stall falls. Reset
// clears the window fill, sums and outlier flag and loads the register
// defaults; cfg_ready is always high.
module interval_jitter_detector_core
	import ijd_pkg::*;
#(
	parameter int WINDOW_DEPTH  = WINDOW_DEPTH_DEF,
	parameter int INTERVAL_BITS = INTERVAL_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [31:0]                       now_ticks,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic                              flag,
	output logic [$clog2(WINDOW_DEPTH+1)-1:0] interval_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [CFG_INDEX_W-1:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0]             cfg_data
);

	localparam int CW = $clog2(WINDOW_DEPTH + 1);

	cmd_t  cmd;
	stat_t stat;
	logic  cfg_we;

	// registers are always writable; the block is idle by contract
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid & cfg_ready;

	ijd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	ijd_dp #(
		.WINDOW_DEPTH  (WINDOW_DEPTH),
		.INTERVAL_BITS (INTERVAL_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.now_ticks      (now_ticks),
		.cmd            (cmd),
		.stat           (stat),
		.flag           (flag),
		.interval_count (interval_count)
	);

`ifndef SYNTHESIS
	// one item at a time: after an input transfer the block is busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while previous item in flight");

	// result register never overwritten while it is still held
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.result |-> !(out_valid && out_stall))
		else $error("result overwritten before transfer");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (interval_count <= CW'(WINDOW_DEPTH)))
		else $error("window count beyond depth");

	a_flag_short: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (interval_count < CW'(2))) |-> flag)
		else $error("flag low with fewer than two intervals");
`endif

endmodule
